// ===== hw/rtl/rti_pkg.sv =====
// ----------------------------------------------------------------------------
// rti_pkg: shared codes for the ray/triangle intersection block
// Register indexes, result status codes and fixed port widths.
// ----------------------------------------------------------------------------
`default_nettype none

package rti_pkg;

  localparam int unsigned ADDR_BITS = 5;
  localparam int unsigned DATA_BITS = 32;
  localparam int unsigned DIST_BITS = 32;
  localparam int unsigned STAT_BITS = 3;
  localparam int unsigned THR_RESET = 43;

  typedef enum logic [2:0] {
    REG_ORG_X = 3'd0,
    REG_ORG_Y = 3'd1,
    REG_ORG_Z = 3'd2,
    REG_DIR_X = 3'd3,
    REG_DIR_Y = 3'd4,
    REG_DIR_Z = 3'd5,
    REG_THR   = 3'd6
  } reg_idx_e;

  typedef enum logic [STAT_BITS-1:0] {
    ST_HIT      = 3'd0,
    ST_PARALLEL = 3'd1,
    ST_U_OUT    = 3'd2,
    ST_V_OUT    = 3'd3,
    ST_BEHIND   = 3'd4
  } status_e;

endpackage

`default_nettype wire

// ===== hw/rtl/ray_triangle_intersect.sv =====
// ----------------------------------------------------------------------------
// ray_triangle_intersect: pipelined Moller-Trumbore ray/triangle test
// One ray in registers, one triangle item in, one result item out.
// ----------------------------------------------------------------------------
// Pipeline: 8 front stages + 32 divider stages + output register.
// Throughput: one item per cycle when not stalled; the 32-step restoring
//   divider for the distance sets the depth, one quotient bit per stage.
// Stall: the whole pipe holds while a finished result waits on out_stall_i.
// Reset: valid bits cleared, ray registers zero, threshold 43.
// ----------------------------------------------------------------------------
`default_nettype none

module ray_triangle_intersect
  import rti_pkg::*;
#(
  parameter int COORD_BITS = 24,
  parameter int FRAC_BITS  = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  // APB-style register port
  input  wire logic                         psel,
  input  wire logic                         penable,
  input  wire logic                         pwrite,
  input  wire logic [ADDR_BITS-1:0]         paddr,
  input  wire logic [DATA_BITS-1:0]         pwdata,
  output logic      [DATA_BITS-1:0]         prdata,
  output logic                              pready,
  // triangle items
  input  wire logic                         in_valid_i,
  output logic                              in_stall_o,
  input  wire logic signed [COORD_BITS-1:0] vert0_x_i,
  input  wire logic signed [COORD_BITS-1:0] vert0_y_i,
  input  wire logic signed [COORD_BITS-1:0] vert0_z_i,
  input  wire logic signed [COORD_BITS-1:0] vert1_x_i,
  input  wire logic signed [COORD_BITS-1:0] vert1_y_i,
  input  wire logic signed [COORD_BITS-1:0] vert1_z_i,
  input  wire logic signed [COORD_BITS-1:0] vert2_x_i,
  input  wire logic signed [COORD_BITS-1:0] vert2_y_i,
  input  wire logic signed [COORD_BITS-1:0] vert2_z_i,
  // result items
  output logic                              out_valid_o,
  input  wire logic                         out_stall_i,
  output logic [STAT_BITS-1:0]              hit_status_o,
  output logic [FRAC_BITS:0]                bary_u_o,
  output logic [FRAC_BITS:0]                bary_v_o,
  output logic [DIST_BITS-1:0]              hit_distance_o
);

  // --- widths -------------------------------------------------------------
  localparam int C    = COORD_BITS;
  localparam int D    = C + 1;          // vertex differences
  localparam int PW   = 2 * D + 1;      // cross product components
  localparam int H    = D + 1;          // low slice of a cross component
  localparam int PHW  = PW - H;         // high slice (signed)
  localparam int LW   = D + H + 1;      // low partial product
  localparam int HW   = D + PHW;        // high partial product
  localparam int W    = 3 * D + 4;      // dot products, headroom for negation
  localparam int RW   = W + 1;          // divider remainder
  localparam int NDIV = DIST_BITS;      // divider stages
  localparam int NUV  = FRAC_BITS + 1;  // steps of the u and v lanes
  localparam int TSH  = DIST_BITS - FRAC_BITS;
  localparam int SH   = 3 * FRAC_BITS - 32;
  localparam int SHD  = (SH < 0) ? -SH : 0;
  localparam int SHT  = (SH > 0) ? SH : 0;
  localparam int CW   = W + 48;         // parallel-test compare width

  // --- configuration registers --------------------------------------------
  logic signed [C-1:0] org_q [3];
  logic signed [C-1:0] dir_q [3];
  logic [31:0]         thr_q;
  logic                cfg_wr;
  reg_idx_e            cfg_idx;

  assign pready  = 1'b1;
  assign cfg_wr  = psel & penable & pwrite;
  assign cfg_idx = reg_idx_e'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        org_q[i] <= '0;
        dir_q[i] <= '0;
      end
      thr_q <= 32'(THR_RESET);
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_ORG_X: org_q[0] <= pwdata[C-1:0];
        REG_ORG_Y: org_q[1] <= pwdata[C-1:0];
        REG_ORG_Z: org_q[2] <= pwdata[C-1:0];
        REG_DIR_X: dir_q[0] <= pwdata[C-1:0];
        REG_DIR_Y: dir_q[1] <= pwdata[C-1:0];
        REG_DIR_Z: dir_q[2] <= pwdata[C-1:0];
        REG_THR:   thr_q    <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_idx)
      REG_ORG_X: prdata = 32'($unsigned(org_q[0]));
      REG_ORG_Y: prdata = 32'($unsigned(org_q[1]));
      REG_ORG_Z: prdata = 32'($unsigned(org_q[2]));
      REG_DIR_X: prdata = 32'($unsigned(dir_q[0]));
      REG_DIR_Y: prdata = 32'($unsigned(dir_q[1]));
      REG_DIR_Z: prdata = 32'($unsigned(dir_q[2]));
      REG_THR:   prdata = thr_q;
      default:   prdata = '0;
    endcase
  end

  // --- pipeline enable ----------------------------------------------------
  // Single global enable: everything moves unless the output is blocked.
  logic en;
  logic out_valid_q;
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // Ray direction must be held in flight (config only when idle); unchecked.
  logic signed [D-1:0] dir_w [3];
  always_comb begin
    for (int i = 0; i < 3; i++) dir_w[i] = D'(dir_q[i]);
  end

  // --- stage 1: edges and origin offset -----------------------------------
  logic                v1_q;
  logic signed [D-1:0] e1_d [3], e2_d [3], t_d [3];
  logic signed [D-1:0] e1_1q [3], e2_1q [3], t_1q [3];
  logic signed [C-1:0] v0 [3], v1 [3], v2 [3];

  assign v0[0] = vert0_x_i; assign v0[1] = vert0_y_i; assign v0[2] = vert0_z_i;
  assign v1[0] = vert1_x_i; assign v1[1] = vert1_y_i; assign v1[2] = vert1_z_i;
  assign v2[0] = vert2_x_i; assign v2[1] = vert2_y_i; assign v2[2] = vert2_z_i;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      e1_d[i] = D'(v1[i]) - D'(v0[i]);
      e2_d[i] = D'(v2[i]) - D'(v0[i]);
      t_d[i]  = D'(org_q[i]) - D'(v0[i]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v1_q <= 1'b0;
    else if (en) v1_q <= in_valid_i;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      e1_1q <= e1_d;
      e2_1q <= e2_d;
      t_1q  <= t_d;
    end
  end

  // --- stage 2: cross product terms ---------------------------------------
  // P = dir x e2, Q = t x e1; a holds the plus term, b the minus term.
  logic                  v2_q;
  logic signed [2*D-1:0] pa_d [3], pb_d [3], qa_d [3], qb_d [3];
  logic signed [2*D-1:0] pa_q [3], pb_q [3], qa_q [3], qb_q [3];
  logic signed [D-1:0]   e1_2q [3], e2_2q [3], t_2q [3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      pa_d[i] = dir_w[(i+1)%3] * e2_1q[(i+2)%3];
      pb_d[i] = dir_w[(i+2)%3] * e2_1q[(i+1)%3];
      qa_d[i] = t_1q[(i+1)%3] * e1_1q[(i+2)%3];
      qb_d[i] = t_1q[(i+2)%3] * e1_1q[(i+1)%3];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v2_q <= 1'b0;
    else if (en) v2_q <= v1_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      pa_q <= pa_d; pb_q <= pb_d; qa_q <= qa_d; qb_q <= qb_d;
      e1_2q <= e1_1q; e2_2q <= e2_1q; t_2q <= t_1q;
    end
  end

  // --- stage 3: cross product components ----------------------------------
  logic                v3_q;
  logic signed [PW-1:0] p_q [3], q_q [3];
  logic signed [D-1:0]  e1_3q [3], e2_3q [3], t_3q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v3_q <= 1'b0;
    else if (en) v3_q <= v2_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        p_q[i] <= PW'(pa_q[i]) - PW'(pb_q[i]);
        q_q[i] <= PW'(qa_q[i]) - PW'(qb_q[i]);
      end
      e1_3q <= e1_2q; e2_3q <= e2_2q; t_3q <= t_2q;
    end
  end

  // --- stage 4: split partial products of the dot products ----------------
  // Dot index: 0 det = e1.P, 1 nu = t.P, 2 nv = dir.Q, 3 nt = e2.Q
  logic                 v4_q;
  logic signed [D-1:0]  ma [4][3];
  logic signed [PW-1:0] mb [4][3];
  logic signed [LW-1:0] lo_q [4][3];
  logic signed [HW-1:0] hi_q [4][3];

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ma[0][i] = e1_3q[i]; mb[0][i] = p_q[i];
      ma[1][i] = t_3q[i];  mb[1][i] = p_q[i];
      ma[2][i] = dir_w[i]; mb[2][i] = q_q[i];
      ma[3][i] = e2_3q[i]; mb[3][i] = q_q[i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v4_q <= 1'b0;
    else if (en) v4_q <= v3_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          lo_q[k][i] <= LW'(ma[k][i] * $signed({1'b0, mb[k][i][H-1:0]}));
          hi_q[k][i] <= HW'(ma[k][i] * $signed(mb[k][i][PW-1:H]));
        end
      end
    end
  end

  // --- stage 5: recombine slices ------------------------------------------
  logic                v5_q;
  logic signed [W-1:0] prod_q [4][3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v5_q <= 1'b0;
    else if (en) v5_q <= v4_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        for (int i = 0; i < 3; i++) begin
          prod_q[k][i] <= (W'(hi_q[k][i]) <<< H) + W'(lo_q[k][i]);
        end
      end
    end
  end

  // --- stage 6: sum of three ----------------------------------------------
  logic                v6_q;
  logic signed [W-1:0] sum_q [4];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v6_q <= 1'b0;
    else if (en) v6_q <= v5_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int k = 0; k < 4; k++) begin
        sum_q[k] <= prod_q[k][0] + prod_q[k][1] + prod_q[k][2];
      end
    end
  end

  // --- stage 7: make det positive -----------------------------------------
  logic                v7_q;
  logic signed [W-1:0] det_q, nu_q, nv_q, nt_q;
  logic                neg;

  assign neg = sum_q[0][W-1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) v7_q <= 1'b0;
    else if (en) v7_q <= v6_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      det_q <= neg ? -sum_q[0] : sum_q[0];
      nu_q  <= neg ? -sum_q[1] : sum_q[1];
      nv_q  <= neg ? -sum_q[2] : sum_q[2];
      nt_q  <= neg ? -sum_q[3] : sum_q[3];
    end
  end

  // --- stage 8: range tests, divider setup --------------------------------
  logic [CW-1:0]         mag, lim;
  logic signed [W:0]     uv_sum;
  status_e               st_d;
  logic [RW-1:0]         rt_init;

  assign mag     = CW'($unsigned(det_q)) << SHD;
  assign lim     = CW'(thr_q) << SHT;
  assign uv_sum  = (W+1)'(nu_q) + (W+1)'(nv_q);
  assign rt_init = RW'($unsigned(nt_q) >> TSH);

  always_comb begin
    priority if (det_q == '0 || mag < lim)                st_d = ST_PARALLEL;
    else if (nu_q[W-1] || det_q < nu_q)                   st_d = ST_U_OUT;
    else if (nv_q[W-1] || (W+1)'(det_q) < uv_sum)         st_d = ST_V_OUT;
    else if (nt_q[W-1])                                   st_d = ST_BEHIND;
    else                                                  st_d = ST_HIT;
  end

  // --- divider pipeline ---------------------------------------------------
  // Restoring division, one quotient bit per stage in three lanes.
  // u, v: floor(n * 2^F / det), F+1 steps, first step takes n itself.
  // t: remainder starts at nt >> (32-F); the low dividend bits shift in.
  logic                  dv_q   [NDIV+1];
  status_e               dst_q  [NDIV+1];
  logic [RW-1:0]         ddet_q [NDIV+1];
  logic [RW-1:0]         ru_q   [NDIV+1];
  logic [RW-1:0]         rv_q   [NDIV+1];
  logic [RW-1:0]         rt_q   [NDIV+1];
  logic [NUV-1:0]        qu_q   [NDIV+1];
  logic [NUV-1:0]        qv_q   [NDIV+1];
  logic [DIST_BITS-1:0]  qt_q   [NDIV+1];
  logic [DIST_BITS-1:0]  tlo_q  [NDIV+1];
  logic                  sat_q  [NDIV+1];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) dv_q[0] <= 1'b0;
    else if (en) dv_q[0] <= v7_q;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      dst_q[0]  <= st_d;
      ddet_q[0] <= RW'($unsigned(det_q));
      ru_q[0]   <= RW'($unsigned(nu_q));
      rv_q[0]   <= RW'($unsigned(nv_q));
      rt_q[0]   <= rt_init;
      qu_q[0]   <= '0;
      qv_q[0]   <= '0;
      qt_q[0]   <= '0;
      tlo_q[0]  <= DIST_BITS'($unsigned(nt_q) << FRAC_BITS);
      sat_q[0]  <= rt_init >= RW'($unsigned(det_q));
    end
  end

  for (genvar k = 0; k < NDIV; k++) begin : g_div
    logic [RW-1:0]        ru_n, rv_n, rt_n;
    logic [NUV-1:0]       qu_n, qv_n;
    logic [DIST_BITS-1:0] qt_n;

    always_comb begin
      // t lane
      rt_n = {rt_q[k][RW-2:0], tlo_q[k][DIST_BITS-1]};
      qt_n = {qt_q[k][DIST_BITS-2:0], 1'b0};
      if (rt_n >= ddet_q[k]) begin
        rt_n    = rt_n - ddet_q[k];
        qt_n[0] = 1'b1;
      end
      // u and v lanes
      ru_n = ru_q[k];
      rv_n = rv_q[k];
      qu_n = qu_q[k];
      qv_n = qv_q[k];
      if (k < NUV) begin
        if (k != 0) begin
          ru_n = {ru_q[k][RW-2:0], 1'b0};
          rv_n = {rv_q[k][RW-2:0], 1'b0};
        end
        qu_n = {qu_q[k][NUV-2:0], 1'b0};
        qv_n = {qv_q[k][NUV-2:0], 1'b0};
        if (ru_n >= ddet_q[k]) begin
          ru_n    = ru_n - ddet_q[k];
          qu_n[0] = 1'b1;
        end
        if (rv_n >= ddet_q[k]) begin
          rv_n    = rv_n - ddet_q[k];
          qv_n[0] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) dv_q[k+1] <= 1'b0;
      else if (en) dv_q[k+1] <= dv_q[k];
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dst_q[k+1]  <= dst_q[k];
        ddet_q[k+1] <= ddet_q[k];
        ru_q[k+1]   <= ru_n;
        rv_q[k+1]   <= rv_n;
        rt_q[k+1]   <= rt_n;
        qu_q[k+1]   <= qu_n;
        qv_q[k+1]   <= qv_n;
        qt_q[k+1]   <= qt_n;
        tlo_q[k+1]  <= {tlo_q[k][DIST_BITS-2:0], 1'b0};
        sat_q[k+1]  <= sat_q[k];
      end
    end
  end

  // --- output register ----------------------------------------------------
  logic [STAT_BITS-1:0] st_q;
  logic [NUV-1:0]       u_q, v_q;
  logic [DIST_BITS-1:0] dist_q;
  logic                 hit;

  assign hit = (dst_q[NDIV] == ST_HIT);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_valid_q <= 1'b0;
    else if (en) out_valid_q <= dv_q[NDIV];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      st_q   <= dst_q[NDIV];
      u_q    <= hit ? qu_q[NDIV] : '0;
      v_q    <= hit ? qv_q[NDIV] : '0;
      dist_q <= !hit ? '0 : (sat_q[NDIV] ? '1 : qt_q[NDIV]);
    end
  end

  assign out_valid_o    = out_valid_q;
  assign hit_status_o   = st_q;
  assign bary_u_o       = u_q;
  assign bary_v_o       = v_q;
  assign hit_distance_o = dist_q;

endmodule

`default_nettype wire
